@@ rtl/itda_pkg.sv @@
// Shared types, constants and the shift-add-3 helper for the integer-to-ASCII block.
package itda_pkg;

  localparam int MAG_W          = 32;
  localparam int NDIG           = 10;
  localparam int BCD_W          = NDIG * 4;
  localparam int BITS_PER_STAGE = 4;
  localparam int DAB_STAGES     = MAG_W / BITS_PER_STAGE;

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [3:0] DIG_FIVE   = 4'd5;
  localparam logic [3:0] DIG_ADJ    = 4'd3;
  localparam logic [3:0] NDIG_ONE   = 4'd1;
  localparam logic [3:0] NDIG_MAX   = 4'd10;

  typedef logic [MAG_W-1:0]     mag_t;
  typedef logic [NDIG-1:0][3:0] bcd_t;
  typedef logic [3:0]           ndig_t;

  // One converted number on its way to the serializer
  typedef struct packed {
    logic  neg;
    bcd_t  digits;
    ndig_t ndig;
  } itda_item_t;

  // One double-dabble step: adjust each digit, then shift in the next binary bit
  function automatic bcd_t dabble_bit(bcd_t b, logic bit_in);
    bcd_t             t;
    logic [BCD_W-1:0] f;
    t = b;
    for (int i = 0; i < NDIG; i++) begin
      if (t[i] >= DIG_FIVE) begin
        t[i] = t[i] + DIG_ADJ;
      end
    end
    f = t;
    f = {f[BCD_W-2:0], bit_in};
    return bcd_t'(f);
  endfunction

endpackage

@@ rtl/itda_conv.sv @@
// Pipelined sign split and binary-to-BCD conversion with digit count.
module itda_conv
  import itda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  logic [31:0] up_value,
  output logic        dn_valid,
  input  logic        dn_ready,
  output itda_item_t  dn_item
);

  // Sign stage
  logic s0_v_r;
  logic s0_neg_r;
  mag_t s0_mag_r;

  // Shift-add-3 stages
  logic [DAB_STAGES-1:0] d_v_r;
  logic [DAB_STAGES-1:0] d_neg_r;
  bcd_t                  d_bcd_r [DAB_STAGES];
  mag_t                  d_bin_r [DAB_STAGES];

  // Digit count stage
  logic  c_v_r;
  logic  c_neg_r;
  bcd_t  c_bcd_r;
  ndig_t c_nd_r;

  logic [DAB_STAGES:0]   acc;
  logic                  s0_acc;
  logic [DAB_STAGES-1:0] p_v;
  logic [DAB_STAGES-1:0] p_neg;
  bcd_t                  p_bcd   [DAB_STAGES];
  mag_t                  p_bin   [DAB_STAGES];
  bcd_t                  d_bcd_nxt [DAB_STAGES];
  mag_t                  d_bin_nxt [DAB_STAGES];
  ndig_t                 c_nd_nxt;
  mag_t                  s0_mag_nxt;

  // Stall chain: a stage takes new data when empty or when its content moves on
  always_comb begin
    acc[DAB_STAGES] = !c_v_r || dn_ready;
    for (int k = DAB_STAGES - 1; k >= 0; k--) begin
      acc[k] = !d_v_r[k] || acc[k+1];
    end
    s0_acc = !s0_v_r || acc[0];
  end

  assign up_ready = s0_acc;

  // Magnitude of the two's complement input; the most negative value maps to itself
  assign s0_mag_nxt = up_value[31] ? (~up_value + 32'd1) : up_value;

  // Feed of each shift stage
  always_comb begin
    p_v[0]   = s0_v_r;
    p_neg[0] = s0_neg_r;
    p_bcd[0] = '0;
    p_bin[0] = s0_mag_r;
    for (int k = 1; k < DAB_STAGES; k++) begin
      p_v[k]   = d_v_r[k-1];
      p_neg[k] = d_neg_r[k-1];
      p_bcd[k] = d_bcd_r[k-1];
      p_bin[k] = d_bin_r[k-1];
    end
  end

  // Each stage consumes four bits, most significant first
  always_comb begin
    for (int k = 0; k < DAB_STAGES; k++) begin
      d_bcd_nxt[k] = p_bcd[k];
      d_bin_nxt[k] = p_bin[k];
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        d_bcd_nxt[k] = dabble_bit(d_bcd_nxt[k], d_bin_nxt[k][MAG_W-1]);
        d_bin_nxt[k] = {d_bin_nxt[k][MAG_W-2:0], 1'b0};
      end
    end
  end

  // Count significant digits, at least one
  always_comb begin
    c_nd_nxt = NDIG_ONE;
    for (int i = 0; i < NDIG; i++) begin
      if (d_bcd_r[DAB_STAGES-1][i] != 4'd0) begin
        c_nd_nxt = ndig_t'(i + 1);
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      d_v_r  <= '0;
      c_v_r  <= 1'b0;
    end else begin
      if (s0_acc) begin
        s0_v_r <= up_valid;
      end
      for (int k = 0; k < DAB_STAGES; k++) begin
        if (acc[k]) begin
          d_v_r[k] <= p_v[k];
        end
      end
      if (acc[DAB_STAGES]) begin
        c_v_r <= d_v_r[DAB_STAGES-1];
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (s0_acc) begin
      s0_neg_r <= up_value[31];
      s0_mag_r <= s0_mag_nxt;
    end
    for (int k = 0; k < DAB_STAGES; k++) begin
      if (acc[k]) begin
        d_neg_r[k] <= p_neg[k];
        d_bcd_r[k] <= d_bcd_nxt[k];
        d_bin_r[k] <= d_bin_nxt[k];
      end
    end
    if (acc[DAB_STAGES]) begin
      c_neg_r <= d_neg_r[DAB_STAGES-1];
      c_bcd_r <= d_bcd_r[DAB_STAGES-1];
      c_nd_r  <= c_nd_nxt;
    end
  end

  assign dn_valid       = c_v_r;
  assign dn_item.neg    = c_neg_r;
  assign dn_item.digits = c_bcd_r;
  assign dn_item.ndig   = c_nd_r;

  a_nd_range: assert property (@(posedge clk) disable iff (!rst_n)
    c_v_r |-> (c_nd_r >= NDIG_ONE) && (c_nd_r <= NDIG_MAX))
    else $error("digit count out of range");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    c_v_r && !dn_ready |=> c_v_r && $stable(c_nd_r) && $stable(c_bcd_r))
    else $error("stalled converted item lost or changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s0_v_r |-> up_ready)
    else $error("empty entry stage refused input");

endmodule

@@ rtl/itda_ser.sv @@
// Serializer: turns one converted number into a run of ASCII character beats.
module itda_ser
  import itda_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  itda_item_t up_item,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic       it_v_r;
  logic       sign_pend_r;
  bcd_t       it_bcd_r;
  ndig_t      dig_idx_r;
  logic       o_v_r;
  logic [7:0] o_char_r;
  logic       o_last_r;

  logic       o_en;
  logic       emit;
  logic       final_emit;
  logic       load;
  logic [3:0] cur_dig;
  logic [7:0] char_nxt;
  logic       last_nxt;

  // Output register takes a new beat when empty or being drained
  assign o_en       = !o_v_r || out_tready;
  assign emit       = o_en && it_v_r;
  assign final_emit = emit && !sign_pend_r && (dig_idx_r == 4'd0);
  assign up_ready   = !it_v_r || final_emit;
  assign load       = up_valid && up_ready;

  // Pick the next character: sign first, then digits from the top
  assign cur_dig = it_bcd_r[dig_idx_r];
  always_comb begin
    if (sign_pend_r) begin
      char_nxt = CHAR_MINUS;
      last_nxt = 1'b0;
    end else begin
      char_nxt = {4'd0, cur_dig} + CHAR_ZERO;
      last_nxt = (dig_idx_r == 4'd0);
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (load) begin
        it_v_r <= 1'b1;
      end else if (final_emit) begin
        it_v_r <= 1'b0;
      end
      if (o_en) begin
        o_v_r <= it_v_r;
      end
    end
  end

  // Item and output payload
  always_ff @(posedge clk) begin
    if (load) begin
      sign_pend_r <= up_item.neg;
      it_bcd_r    <= up_item.digits;
      dig_idx_r   <= up_item.ndig - NDIG_ONE;
    end else if (emit) begin
      if (sign_pend_r) begin
        sign_pend_r <= 1'b0;
      end else begin
        dig_idx_r <= dig_idx_r - 4'd1;
      end
    end
    if (emit) begin
      o_char_r <= char_nxt;
      o_last_r <= last_nxt;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = o_char_r;
  assign out_tlast  = o_last_r;

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata == CHAR_MINUS) |-> !out_tlast)
    else $error("minus sign marked as last character");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == CHAR_MINUS) ||
                   ((out_tdata >= CHAR_ZERO) && (out_tdata <= CHAR_NINE)))
    else $error("character outside sign and digit set");

  a_no_load_on_sign: assert property (@(posedge clk) disable iff (!rst_n)
    it_v_r && sign_pend_r |-> !up_ready)
    else $error("new number taken before current run ended");

endmodule

@@ rtl/int_to_decimal_ascii_top.sv @@
// Top level of the signed 32-bit integer to decimal ASCII converter.
//
// Input channel (in_*): one beat carries one signed 32-bit value in in_tdata.
// Output channel (out_*): one beat carries one ASCII character in out_tdata;
// a negative number starts with '-', then the digits follow, most
// significant first, with no leading zeros; zero gives a single '0'.
// out_tlast marks the final character of each number.
// The first character of a number, once its input beat is accepted, passes
// through the sign stage, eight shift-add-3 stages of four bits each, the
// digit count stage, the serializer's item register and the output register.
// A number with n characters (1 to 11) takes n beats on the output port;
// the single character port sets the rate, and numbers follow each other
// with no gap beats while the converter has the next number ready.
// Reset (rst_n low, synchronous) empties every stage; nothing else is kept.
// When the receiver holds out_tready low the output beat holds, stages fill
// up and then hold, and in_tready drops once the pipeline has filled up.
module int_to_decimal_ascii_top
  import itda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value (signed)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] char_code
  output logic        out_tlast
);

  logic       cv_valid;
  logic       cv_ready;
  itda_item_t cv_item;

  // Convert value to sign, BCD digits and digit count
  itda_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_value (in_tdata),
    .dn_valid (cv_valid),
    .dn_ready (cv_ready),
    .dn_item  (cv_item)
  );

  // Emit characters one beat at a time
  itda_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (cv_valid),
    .up_ready   (cv_ready),
    .up_item    (cv_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
